[rtl/mbld_pkg.sv]
// Package for the multi-button lockout debouncer.
// Holds the button count, the field widths and the reset value of the interval.
// It depends on nothing. The RTL and the checker both use it.
package mbld_pkg;

  localparam int BUTTON_COUNT = 12;
  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int TIME_W = 32;
  localparam int INTERVAL_W = 16;
  localparam int NUM_W = 4;
  localparam int S_TDATA_W = ((TIME_W + BUTTON_COUNT + 7) / 8) * 8;
  localparam int M_TDATA_W = ((NUM_W + 1 + 7) / 8) * 8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);
  localparam logic [INTERVAL_W-1:0] DEBOUNCE_RESET = INTERVAL_W'(50);

endpackage

[rtl/multi_button_lockout_debouncer.sv]
// Top level of the multi-button lockout debouncer.
// It keeps the last change times in a synchronous memory and walks the buttons.
// It depends on mbld_pkg.
//
// Each request on the slave stream is one poll tick. s_axis_tdata carries
// time_now in bits 31:0 and pin_levels in bits 43:32, where a low bit means
// that the button is pressed. The buttons are examined in index order, one per
// cycle while the walk is not paused. Their last change times come from a
// memory with a registered read, and each change that passes its lockout is
// written back as it is found. Every accepted change leaves as one request
// on the master stream: button_number in tdata bits 3:0, is_pressed in bit 4,
// and tlast set on the final event of the tick. A tick with no accepted
// change sends nothing. The block takes one tick at a time and accepts a new
// one only once the walk of the last has ended and its pipeline has drained.
// The walk is bound by the single memory read port, visited once per button.
// One event is held back until the next one or the end of the tick is known,
// so that tlast can be set on the right one. When the receiver stalls and an
// event is found while another is still held back, the walk pauses with its
// read data held. The interval register may be written at any cycle through
// cfg_valid and cfg_data, and cfg_ready is always high. Reset sets the
// interval to 50, marks every button as released and treats every change
// time as zero.
module multi_button_lockout_debouncer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // time_now [31:0], pin_levels [43:32], zero [47:44]
  input  logic [mbld_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // button_number [3:0], is_pressed [4], zero [7:5]
  output logic [mbld_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mbld_pkg::INTERVAL_W-1:0] cfg_data
);

  logic [mbld_pkg::INTERVAL_W-1:0]   interval;
  logic [mbld_pkg::TIME_W-1:0]       change_mem [mbld_pkg::BUTTON_COUNT];
  logic [mbld_pkg::TIME_W-1:0]       rdata;
  logic [mbld_pkg::BUTTON_COUNT-1:0] written;
  logic [mbld_pkg::BUTTON_COUNT-1:0] stable;

  logic [mbld_pkg::TIME_W-1:0]       tick_time;
  logic [mbld_pkg::BUTTON_COUNT-1:0] tick_pressed;

  logic                              rd_active;
  logic [mbld_pkg::IDX_W-1:0]        rd_idx;
  logic                              s2_valid;
  logic [mbld_pkg::IDX_W-1:0]        s2_idx;
  logic                              flush;

  logic                              pend_valid;
  logic [mbld_pkg::IDX_W-1:0]        pend_idx;
  logic                              pend_pressed;

  logic                              out_valid;
  logic [mbld_pkg::IDX_W-1:0]        out_idx;
  logic                              out_pressed;
  logic                              out_last;

  logic [mbld_pkg::TIME_W-1:0]       base_time;
  logic [mbld_pkg::TIME_W-1:0]       elapsed;
  logic                              cur_pressed;
  logic                              evt;
  logic                              out_free;
  logic                              out_load;
  logic                              adv;
  logic                              in_accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !rd_active && !s2_valid && !flush;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign cur_pressed = tick_pressed[s2_idx];
  assign base_time   = written[s2_idx] ? rdata : '0;
  assign elapsed     = tick_time - base_time;
  assign evt = s2_valid && (cur_pressed != stable[s2_idx])
               && (elapsed >= mbld_pkg::TIME_W'(interval));

  assign out_free = !out_valid || m_axis_tready;
  assign adv      = !evt || !pend_valid || out_free;
  assign out_load = out_free && pend_valid && ((evt && adv) || flush);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(mbld_pkg::M_TDATA_W - mbld_pkg::NUM_W - 1){1'b0}},
                          out_pressed, mbld_pkg::NUM_W'(out_idx)};
  assign m_axis_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= mbld_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_active && adv) begin
      rdata <= change_mem[rd_idx];
    end
    if (evt && adv) begin
      change_mem[s2_idx] <= tick_time;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_time    <= s_axis_tdata[mbld_pkg::TIME_W-1:0];
      tick_pressed <= ~s_axis_tdata[mbld_pkg::TIME_W +: mbld_pkg::BUTTON_COUNT];
    end
    if (rd_active && adv) begin
      s2_idx <= rd_idx;
    end
    if (evt && adv) begin
      pend_idx     <= s2_idx;
      pend_pressed <= cur_pressed;
    end
    if (out_load) begin
      out_idx     <= pend_idx;
      out_pressed <= pend_pressed;
      out_last    <= flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      stable     <= '0;
      rd_active  <= 1'b0;
      rd_idx     <= '0;
      s2_valid   <= 1'b0;
      flush      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept) begin
        rd_active <= 1'b1;
        rd_idx    <= '0;
      end else if (rd_active && adv) begin
        rd_idx <= rd_idx + 1'b1;
        if (rd_idx == mbld_pkg::LAST_IDX) begin
          rd_active <= 1'b0;
        end
      end

      if (adv) begin
        s2_valid <= rd_active;
      end

      if (evt && adv) begin
        written[s2_idx] <= 1'b1;
        stable[s2_idx]  <= cur_pressed;
      end

      if (s2_valid && adv && (s2_idx == mbld_pkg::LAST_IDX)) begin
        flush <= 1'b1;
      end else if (flush && (!pend_valid || out_load)) begin
        flush <= 1'b0;
      end

      if (evt && adv) begin
        pend_valid <= 1'b1;
      end else if (out_load) begin
        pend_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/mbld_checker.sv]
// Port checker for the multi-button lockout debouncer, with its bind statement.
// It watches only the top level's ports.
// It depends on mbld_pkg and on multi_button_lockout_debouncer.
module mbld_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mbld_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("A stalled result request changed or was withdrawn.");

  a_button_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[mbld_pkg::NUM_W-1:0] < mbld_pkg::NUM_W'(mbld_pkg::BUTTON_COUNT)))
    else $error("An event names a button that does not exist.");

  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("A tick was accepted while another was being processed.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("An event was offered straight after reset.");

endmodule

bind multi_button_lockout_debouncer mbld_checker u_mbld_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
